FILE: hdl/point_cloud_to_polar_min_scan_macros.svh
// Assertion macros used by the scan block's top level.
`ifndef POINT_CLOUD_TO_POLAR_MIN_SCAN_MACROS_SVH
`define POINT_CLOUD_TO_POLAR_MIN_SCAN_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PCPMS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define PCPMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/pcpms_pkg.sv
// Shared types, constants and the arctangent table of the polar scan block.
package pcpms_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int LIFT_BITS    = 12;
  localparam int RANGE_BITS   = 18;
  localparam int HEIGHT_BITS  = 18;
  localparam int SEL_BITS     = 9;
  localparam logic [RANGE_BITS-1:0] RANGE_SAT = '1;

  // Configuration register indexes.
  localparam logic REG_Z_FLOOR = 1'b0;
  localparam logic REG_Z_CEIL  = 1'b1;

  // Result of the geometry unit: bearing offset by a half turn, and planar range.
  typedef struct packed {
    logic [31:0]           turn;
    logic [RANGE_BITS-1:0] range;
  } geom_res_t;

  // atan(2^-i) in units of 2^-32 of a full turn, truncated.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051D;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2E;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2F9;
      5'd15: t = 32'h0000517C;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A2F;
      5'd19: t = 32'h00000517;
      5'd20: t = 32'h0000028B;
      5'd21: t = 32'h00000145;
      5'd22: t = 32'h000000A2;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000028;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000002;
      5'd29: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/pcpms_if.sv
// Valid/ready channel interfaces for points in and bin read-outs out.
interface pcpms_in_if #(parameter int COORD_BITS = 18);
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [COORD_BITS-1:0]     point_x;
  logic signed [COORD_BITS-1:0]     point_y;
  logic signed [COORD_BITS-1:0]     point_z;
  logic [pcpms_pkg::SEL_BITS-1:0]   bin_select;

  modport source (output valid, mode, point_x, point_y, point_z, bin_select, input ready);
  modport sink (input valid, mode, point_x, point_y, point_z, bin_select, output ready);
endinterface

interface pcpms_out_if;
  logic                               valid;
  logic                               ready;
  logic [pcpms_pkg::SEL_BITS-1:0]     bin_index;
  logic [pcpms_pkg::RANGE_BITS-1:0]   range_mm;
  logic                               bin_empty;

  modport source (output valid, bin_index, range_mm, bin_empty, input ready);
  modport sink (input valid, bin_index, range_mm, bin_empty, output ready);
endinterface

FILE: hdl/point_cloud_to_polar_min_scan.sv
// Top level: height filter, bin store and read-out control of the polar scan.
//
//  channel   | direction | payload
//  points    | in        | mode, point_x, point_y, point_z, bin_select
//  scan      | out       | bin_index, range_mm, bin_empty
//  cfg       | in        | cfg_wr_en, cfg_index, cfg_wr_data (write only)
//
// A point in the height band and off the negative x axis goes to the geometry
// unit, which runs one CORDIC step and one square root step per cycle; then the
// bin is computed, read and updated in the store before the next item is taken.
// A filtered-out point leaves the block idle; a bin read goes through the
// read-out state first.  After reset the store is swept clear, and no item is
// taken during the sweep.  A read whose output register is still full waits,
// and no item is taken until its read-out moves into the register.
`include "point_cloud_to_polar_min_scan_macros.svh"

module point_cloud_to_polar_min_scan #(
  parameter int BIN_COUNT  = 360,
  parameter int COORD_BITS = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  pcpms_in_if.sink                            points,
  pcpms_out_if.source                         scan,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [pcpms_pkg::HEIGHT_BITS-1:0]   cfg_wr_data
);

  localparam int BIN_W = $clog2(BIN_COUNT);
  localparam int BCW   = $clog2(BIN_COUNT + 1);
  localparam int PW    = 32 + BCW;
  localparam int HW    = ((COORD_BITS > pcpms_pkg::HEIGHT_BITS) ?
                          COORD_BITS : pcpms_pkg::HEIGHT_BITS) + 1;
  localparam int RB    = pcpms_pkg::RANGE_BITS;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_GEOM = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state;

  // Height band registers.
  logic signed [pcpms_pkg::HEIGHT_BITS-1:0] z_floor;
  logic signed [pcpms_pkg::HEIGHT_BITS-1:0] z_ceil;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_floor <= -18'sd2000;
      z_ceil  <= 18'sd2000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pcpms_pkg::REG_Z_FLOOR: z_floor <= signed'(cfg_wr_data);
        pcpms_pkg::REG_Z_CEIL:  z_ceil  <= signed'(cfg_wr_data);
        default: ;
      endcase
    end
  end

  // Bin store: one entry per bin, hit flag on top of the minimum range.
  logic [RB:0]        mem [BIN_COUNT];
  logic [RB:0]        rd_q;
  logic               mem_re;
  logic [BIN_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [BIN_W-1:0]   mem_waddr;
  logic [RB:0]        mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Input decode.
  logic                 accept;
  logic signed [HW-1:0] z_w;
  logic signed [HW-1:0] lo_w;
  logic signed [HW-1:0] hi_w;
  logic                 in_band;
  logic                 neg_x_axis;
  logic [31:0]          sel_w;
  logic                 sel_in_range;
  logic                 geom_start;

  assign points.ready = (state == ST_IDLE);
  assign accept       = points.valid && points.ready;

  always_comb begin
    z_w          = HW'(points.point_z);
    lo_w         = HW'(z_floor);
    hi_w         = HW'(z_ceil);
    in_band      = (z_w >= lo_w) && (z_w <= hi_w);
    // Points on the negative x axis are dropped.
    neg_x_axis   = (points.point_y == '0) && points.point_x[COORD_BITS-1];
    sel_w        = 32'(points.bin_select);
    sel_in_range = sel_w < 32'(BIN_COUNT);
    geom_start   = accept && !points.mode && in_band && !neg_x_axis;
  end

  // Geometry unit.
  logic                 g_done;
  pcpms_pkg::geom_res_t g_res;

  pcpms_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk   (clk),
    .rst   (rst),
    .start (geom_start),
    .x     (points.point_x),
    .y     (points.point_y),
    .done  (g_done),
    .res   (g_res)
  );

  // Item registers.
  logic [pcpms_pkg::SEL_BITS-1:0] sel;
  logic                           sel_ok;
  logic [BIN_W-1:0]               sel_addr;
  logic [PW-1:0]                  prod;
  logic [RB-1:0]                  range_r;
  logic [BIN_W-1:0]               clr_addr;
  logic [BIN_W-1:0]               bin;
  logic                           out_free;

  assign bin      = prod[32 +: BIN_W];
  assign out_free = !scan.valid || scan.ready;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = bin;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    unique case (state)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        // A selector past the last bin reads nothing.
        mem_re    = accept && points.mode && sel_in_range;
        mem_raddr = sel_w[BIN_W-1:0];
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_UPD: begin
        // Keep the smaller range; an empty bin takes any range.
        mem_we    = !rd_q[RB] || (range_r < rd_q[RB-1:0]);
        mem_waddr = bin;
        mem_wdata = {1'b1, range_r};
      end
      ST_OUT: begin
        // Reading a bin clears it for the next frame.
        mem_we    = out_free && sel_ok;
        mem_waddr = sel_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLR: begin
          if (clr_addr == BIN_W'(BIN_COUNT - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept && points.mode) begin
            state <= ST_OUT;
          end else if (geom_start) begin
            state <= ST_GEOM;
          end
        end
        ST_GEOM: begin
          if (g_done) begin
            state <= ST_RD;
          end
        end
        ST_RD:   state <= ST_UPD;
        ST_UPD:  state <= ST_IDLE;
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && points.mode) begin
      sel      <= points.bin_select;
      sel_ok   <= sel_in_range;
      sel_addr <= sel_w[BIN_W-1:0];
    end
    if (state == ST_GEOM && g_done) begin
      prod    <= PW'(g_res.turn) * PW'(BIN_COUNT);
      range_r <= g_res.range;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan.valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      scan.valid <= 1'b1;
    end else if (scan.ready) begin
      scan.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      scan.bin_index <= sel;
      scan.range_mm  <= (sel_ok && rd_q[RB]) ? rd_q[RB-1:0] : '0;
      scan.bin_empty <= !(sel_ok && rd_q[RB]);
    end
  end

  `PCPMS_ASSERT_IMPL(a_wr_range, mem_we, mem_waddr <= BIN_W'(BIN_COUNT - 1), "bad store write")
  `PCPMS_ASSERT_IMPL(a_out_src, $rose(scan.valid), $past(state) == ST_OUT, "stray read-out")
  `PCPMS_ASSERT_IMPL(a_done_in_geom, g_done, state == ST_GEOM, "early geometry result")

endmodule

FILE: hdl/pcpms_geom.sv
// Iterative bearing (CORDIC vectoring) and planar range (integer square root) unit.
module pcpms_geom #(
  parameter int COORD_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  output logic                         done,
  output pcpms_pkg::geom_res_t         res
);

  localparam int CW    = COORD_BITS + pcpms_pkg::LIFT_BITS + 3;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int LAST  = (pcpms_pkg::CORDIC_STEPS > COORD_BITS + 2) ?
                         pcpms_pkg::CORDIC_STEPS : COORD_BITS + 2;
  localparam int CNT_W = $clog2(LAST + 1);
  localparam logic signed [35:0] HALF_TURN = 36'sh080000000;
  localparam logic signed [34:0] HALF_ANG  = 35'sh080000000;

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic signed [CW-1:0]   cx;
  logic signed [CW-1:0]   cy;
  logic signed [34:0]     ang;
  logic                   fixed;
  logic [31:0]            fixed_turn;
  logic [COORD_BITS-1:0]  ax;
  logic [COORD_BITS-1:0]  ay;
  logic [SQ_W-1:0]        sq_x;
  logic [SQ_W-1:0]        sq_y;
  logic [SQ_W-1:0]        rem;
  logic [SQ_W-1:0]        root;
  logic [SQ_W-1:0]        sbit;

  logic signed [COORD_BITS:0] xe;
  logic signed [COORD_BITS:0] ye;
  logic signed [COORD_BITS:0] xn;
  logic signed [COORD_BITS:0] yn;
  logic signed [COORD_BITS:0] x_mag;
  logic signed [COORD_BITS:0] y_mag;
  logic [4:0]                 step_i;
  logic signed [CW-1:0]       xs;
  logic signed [CW-1:0]       ys;
  logic signed [34:0]         t_ext;
  logic [SQ_W-1:0]            trial;
  logic signed [35:0]         turn_full;
  logic [63:0]                root_w;

  always_comb begin
    xe     = (COORD_BITS + 1)'(x);
    ye     = (COORD_BITS + 1)'(y);
    xn     = xe[COORD_BITS] ? -xe : xe;
    yn     = xe[COORD_BITS] ? -ye : ye;
    x_mag  = xe[COORD_BITS] ? -xe : xe;
    y_mag  = ye[COORD_BITS] ? -ye : ye;
    step_i = cnt[4:0];
    xs     = cx >>> step_i;
    ys     = cy >>> step_i;
    t_ext  = signed'({3'b000, pcpms_pkg::atan_turn(step_i)});
    trial  = root + sbit;
    turn_full = 36'(ang) + HALF_TURN;
    root_w = 64'(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(LAST)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Fold left half plane to the right; a folded point starts at +/- half a turn.
      cx <= CW'(xn) <<< pcpms_pkg::LIFT_BITS;
      cy <= CW'(yn) <<< pcpms_pkg::LIFT_BITS;
      if (!xe[COORD_BITS]) begin
        ang <= '0;
      end else if (!ye[COORD_BITS]) begin
        ang <= HALF_ANG;
      end else begin
        ang <= -HALF_ANG;
      end
      // Points on an axis have an exact bearing.
      fixed <= (y == '0) || (x == '0);
      if (y == '0) begin
        fixed_turn <= 32'h80000000;
      end else if (!ye[COORD_BITS]) begin
        fixed_turn <= 32'hC0000000;
      end else begin
        fixed_turn <= 32'h40000000;
      end
      ax <= COORD_BITS'(x_mag);
      ay <= COORD_BITS'(y_mag);
    end else if (busy) begin
      if (cnt < CNT_W'(pcpms_pkg::CORDIC_STEPS)) begin
        if (!cy[CW-1]) begin
          cx  <= cx + ys;
          cy  <= cy - xs;
          ang <= ang + t_ext;
        end else begin
          cx  <= cx - ys;
          cy  <= cy + xs;
          ang <= ang - t_ext;
        end
      end
      if (cnt == CNT_W'(0)) begin
        sq_x <= ax * ax;
        sq_y <= ay * ay;
      end else if (cnt == CNT_W'(1)) begin
        rem  <= sq_x + sq_y;
        root <= '0;
        sbit <= SQ_W'(1) << (SQ_W - 2);
      end else if (cnt <= CNT_W'(COORD_BITS + 1)) begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      if (cnt == CNT_W'(LAST)) begin
        if (fixed) begin
          res.turn <= fixed_turn;
        end else if (turn_full[35]) begin
          res.turn <= '0;
        end else if (turn_full[35:32] != 4'd0) begin
          res.turn <= '1;
        end else begin
          res.turn <= turn_full[31:0];
        end
        if (root_w > 64'(pcpms_pkg::RANGE_SAT)) begin
          res.range <= pcpms_pkg::RANGE_SAT;
        end else begin
          res.range <= root_w[pcpms_pkg::RANGE_BITS-1:0];
        end
      end
    end
  end

endmodule
